@@ hdl/pblog_pkg.sv @@
// ----------------------------------------------------------------------------
// pblog_pkg: shared types and codes of the log message parser
// Event record, per-byte event bundle, event kinds and error codes.
// ----------------------------------------------------------------------------
package pblog_pkg;

  localparam int MaxEv = 3;

  localparam logic [2:0] EV_INT   = 3'd0;
  localparam logic [2:0] EV_STR   = 3'd1;
  localparam logic [2:0] EV_DBL   = 3'd2;
  localparam logic [2:0] EV_BOOL  = 3'd3;
  localparam logic [2:0] EV_REND  = 3'd4;
  localparam logic [2:0] EV_OK    = 3'd5;
  localparam logic [2:0] EV_ERR   = 3'd6;
  localparam logic [2:0] EV_EMPTY = 3'd7;

  localparam logic [3:0] ERR_WIRE     = 4'd1;
  localparam logic [3:0] ERR_OVERLONG = 4'd2;
  localparam logic [3:0] ERR_OVERRUN  = 4'd3;
  localparam logic [3:0] ERR_TAG      = 4'd4;
  localparam logic [3:0] ERR_UUID     = 4'd5;
  localparam logic [3:0] ERR_NONAME   = 4'd6;
  localparam logic [3:0] ERR_MISSING  = 4'd7;
  localparam logic [3:0] ERR_SHORT    = 4'd8;
  localparam logic [3:0] ERR_TRUNC    = 4'd9;
  localparam logic [3:0] ERR_PACKDBL  = 4'd10;

  localparam logic [7:0] MIN_LEN_RST = 8'd20;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [3:0]  message_tag;
    logic [3:0]  record_tag;
    logic [63:0] value_word;
    logic [7:0]  string_byte;
    logic        string_last;
    logic [15:0] record_number;
    logic [3:0]  error_code;
  } event_t;

  typedef struct packed {
    event_t [MaxEv-1:0] ev;
    logic [1:0]         cnt;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic event_t mk_ev(logic [2:0] kind, logic [63:0] value, logic [7:0] sb,
                                   logic sl, logic [3:0] err, logic [10:0] ctw,
                                   logic [15:0] rcnt);
    event_t e;
    e.event_kind    = kind;
    e.message_tag   = ctw[3:0];
    e.record_tag    = ctw[7:4];
    e.value_word    = value;
    e.string_byte   = sb;
    e.string_last   = sl;
    e.record_number = (ctw[3:0] == 4'd10) ? rcnt : 16'd0;
    e.error_code    = err;
    return e;
  endfunction

endpackage

@@ hdl/pblog_if.sv @@
// ----------------------------------------------------------------------------
// pblog_if: word channels of the log message parser
// Byte input channel and event output channel, valid/ready.
// ----------------------------------------------------------------------------
interface pblog_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] message_bytes;
  modport source (output valid, data_byte, first_byte, message_bytes, input ready);
  modport sink (input valid, data_byte, first_byte, message_bytes, output ready);
endinterface

interface pblog_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [3:0]  message_tag;
  logic [3:0]  record_tag;
  logic [63:0] value_word;
  logic [7:0]  string_byte;
  logic        string_last;
  logic [15:0] record_number;
  logic [3:0]  error_code;
  logic        last_of_run;
  modport source (output valid, event_kind, message_tag, record_tag, value_word, string_byte,
                  string_last, record_number, error_code, last_of_run, input ready);
  modport sink (input valid, event_kind, message_tag, record_tag, value_word, string_byte,
                string_last, record_number, error_code, last_of_run, output ready);
endinterface

@@ hdl/protobuf_log_message_parser.sv @@
// ----------------------------------------------------------------------------
// protobuf_log_message_parser: streaming log message decoder
// Each taken word's events go into the queue as one registered bundle.
// Takes one word per cycle while the queue is not full; a word giving k events
// sends them one at a time, and the two-bundle queue absorbs short bursts.
// Reset (rst_n low, synchronous): parser waits for a key, queue empty,
// min_message_length back to 20.
// ----------------------------------------------------------------------------
module protobuf_log_message_parser (
  input  logic          clk,
  input  logic          rst_n,
  pblog_byte_if.sink    in_byte,
  pblog_event_if.source out_event,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata
);

  // configuration: minimum message length
  logic [7:0] min_len_r;

  // front to queue to back
  logic               push;
  logic               pop;
  pblog_pkg::bundle_t push_data;
  pblog_pkg::bundle_t head;
  pblog_pkg::q_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= pblog_pkg::MIN_LEN_RST;
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  // byte parser: all per-word decoding, emits up to three events as a bundle
  pblog_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_byte),
    .min_len (min_len_r),
    .q_full  (stat.full),
    .push    (push),
    .bundle  (push_data)
  );

  // bundle queue: lets the parser run on while events drain
  pblog_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  // serialiser: one event per word on the output
  pblog_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_event (out_event)
  );

  a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue full and empty at once");

  a_cfg_rst: assert property (@(posedge clk) !rst_n |=> min_len_r == pblog_pkg::MIN_LEN_RST)
    else $error("min length not restored by reset");

  a_cfg_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> min_len_r == $past(cfg_wdata))
    else $error("config write lost");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full queue");

endmodule

@@ hdl/pblog_front.sv @@
// ----------------------------------------------------------------------------
// pblog_front: byte parser
// Takes one word a cycle while the queue is not full, updates parser state, hands its events on as a bundle.
// ----------------------------------------------------------------------------
module pblog_front (
  input  logic                clk,
  input  logic                rst_n,
  pblog_byte_if.sink          in_byte,
  input  logic [7:0]          min_len,
  input  logic                q_full,
  output logic                push,
  output pblog_pkg::bundle_t  bundle
);

  localparam logic [2:0] PH_KEY   = 3'd0;
  localparam logic [2:0] PH_VAR   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_STR   = 3'd3;
  localparam logic [2:0] PH_DBL   = 3'd4;
  localparam logic [2:0] PH_PACKV = 3'd5;
  localparam logic [2:0] PH_IDLE  = 3'd6;

  logic [2:0]  ph_r, ph_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  vcnt_r, vcnt_nxt;
  logic [15:0] mrem_r, mrem_nxt;
  logic [15:0] rrem_r, rrem_nxt;
  logic [15:0] irem_r, irem_nxt;
  logic [10:0] ctw_r, ctw_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic [15:0] rcnt_r, rcnt_nxt;
  pblog_pkg::event_t [pblog_pkg::MaxEv-1:0] ev_nxt;
  logic [1:0]  n_nxt;
  logic        take;

  assign in_byte.ready = !q_full;
  assign take          = in_byte.valid && !q_full;
  assign push          = take && (n_nxt != 2'd0);
  assign bundle.ev     = ev_nxt;
  assign bundle.cnt    = n_nxt;

  always_comb begin
    logic        inrec;
    logic [7:0]  b;
    logic [4:0]  tag;
    logic [2:0]  wt;
    logic        ok;
    logic [63:0] vs_acc;
    logic [3:0]  vs_cnt;
    logic [1:0]  vr;
    logic [63:0] len;
    logic [15:0] avail;
    logic [3:0]  mt;
    logic [3:0]  rt;
    logic [2:0]  ekind;
    logic [63:0] eval;
    b = in_byte.data_byte;
    tag = b[7:3];
    wt = b[2:0];
    ok = 1'b0;
    len = 64'd0;
    avail = 16'd0;
    mt = 4'd0;
    rt = 4'd0;
    inrec = 1'b0;
    ph_nxt = ph_r;
    acc_nxt = acc_r;
    vcnt_nxt = vcnt_r;
    mrem_nxt = mrem_r;
    rrem_nxt = rrem_r;
    irem_nxt = irem_r;
    ctw_nxt = ctw_r;
    seen_nxt = seen_r;
    rcnt_nxt = rcnt_r;
    ev_nxt = '0;
    n_nxt = 2'd0;
    vs_acc = 64'd0;
    vs_cnt = 4'd0;
    vr = 2'd0;
    ekind = pblog_pkg::EV_INT;
    eval = 64'd0;

    if (in_byte.first_byte) begin
      ph_nxt = PH_KEY;
      acc_nxt = 64'd0;
      vcnt_nxt = 4'd0;
      mrem_nxt = in_byte.message_bytes;
      rrem_nxt = 16'd0;
      irem_nxt = 16'd0;
      ctw_nxt = 11'd0;
      seen_nxt = 4'd0;
      rcnt_nxt = 16'd0;
      if (in_byte.message_bytes < {8'd0, min_len}) begin
        ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                         pblog_pkg::ERR_SHORT, ctw_nxt, rcnt_nxt);
        n_nxt = n_nxt + 2'd1;
        ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
      end else if (in_byte.message_bytes == 16'd0) begin
        ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                         pblog_pkg::ERR_MISSING, ctw_nxt, rcnt_nxt);
        n_nxt = n_nxt + 2'd1;
        ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
      end
    end

    if (ph_nxt != PH_IDLE && mrem_nxt != 16'd0) begin
      inrec = rrem_nxt != 16'd0;
      mrem_nxt = mrem_nxt - 16'd1;
      if (inrec) rrem_nxt = rrem_nxt - 16'd1;
      if ((ph_nxt == PH_STR || ph_nxt == PH_DBL || ph_nxt == PH_PACKV) && irem_nxt != 16'd0)
        irem_nxt = irem_nxt - 16'd1;

      // one varint step, used by the varint, length and packed phases
      vs_acc = acc_nxt;
      if (vcnt_nxt < 4'd10)
        vs_acc = acc_nxt | (64'(b[6:0]) << (7'(vcnt_nxt) * 7'd7));
      vs_cnt = vcnt_nxt + 4'd1;
      if (!b[7])                vr = 2'd1;
      else if (vs_cnt >= 4'd10) vr = 2'd2;
      else                      vr = 2'd0;

      // plain integer or bool value
      if (inrec && ctw_nxt[7:4] == 4'd8) begin
        ekind = pblog_pkg::EV_BOOL; eval = 64'(vs_acc != 64'd0);
      end else begin
        ekind = pblog_pkg::EV_INT;  eval = vs_acc;
      end

      unique case (ph_nxt)
        PH_KEY: begin
          acc_nxt = 64'd0; vcnt_nxt = 4'd0;
          if (!inrec) begin
            ctw_nxt = {wt, 4'd0, tag[3:0]};
            ok = (tag == 5'd2 || tag == 5'd5 || tag == 5'd8) ? (wt == 3'd0) : (wt == 3'd2);
          end else begin
            ctw_nxt = {wt, tag[3:0], 4'd10};
            if (tag == 5'd2)                     ok = (wt == 3'd0);
            else if (tag == 5'd6 || tag == 5'd8) ok = (wt == 3'd0 || wt == 3'd2);
            else if (tag == 5'd7)                ok = (wt == 3'd1 || wt == 3'd2);
            else                                 ok = (wt == 3'd2);
          end
          if (tag < 5'd1 || tag > (inrec ? 5'd8 : 5'd10)) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_TAG, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
          end else if (!ok) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_WIRE, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
          end else if (wt == 3'd0) begin
            ph_nxt = PH_VAR;
          end else if (wt == 3'd2) begin
            ph_nxt = PH_LEN;
          end else if (rrem_nxt < 16'd8) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_OVERRUN, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
          end else begin
            irem_nxt = 16'd8; ph_nxt = PH_DBL;
          end
        end
        PH_VAR: begin
          acc_nxt = vs_acc; vcnt_nxt = vs_cnt;
          if (vr == 2'd2) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_OVERLONG, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
          end else if (vr == 2'd1) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(ekind, eval, 8'd0, 1'b0, 4'd0, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            if (!inrec && ctw_nxt[3:0] == 4'd2) seen_nxt[1] = 1'b1;
            ph_nxt = PH_KEY;
          end
        end
        PH_LEN: begin
          acc_nxt = vs_acc; vcnt_nxt = vs_cnt;
          if (vr == 2'd2) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_OVERLONG, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
          end else if (vr == 2'd1) begin
            len = vs_acc;
            avail = inrec ? rrem_nxt : mrem_nxt;
            mt = ctw_nxt[3:0];
            rt = ctw_nxt[7:4];
            acc_nxt = 64'd0; vcnt_nxt = 4'd0;
            ph_nxt = PH_KEY;
            if (len > 64'(avail)) begin
              ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                               pblog_pkg::ERR_OVERRUN, ctw_nxt, rcnt_nxt);
              n_nxt = n_nxt + 2'd1;
              ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
            end else if (!inrec && mt == 4'd1 && len != 64'd16) begin
              ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                               pblog_pkg::ERR_UUID, ctw_nxt, rcnt_nxt);
              n_nxt = n_nxt + 2'd1;
              ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
            end else if (!inrec && mt == 4'd10) begin
              // opening a field record
              if (rcnt_nxt != 16'hffff) rcnt_nxt = rcnt_nxt + 16'd1;
              seen_nxt[2] = 1'b0;
              if (len == 64'd0) begin
                ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                                 pblog_pkg::ERR_NONAME, ctw_nxt, rcnt_nxt);
                n_nxt = n_nxt + 2'd1;
                ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
              end else begin
                rrem_nxt = len[15:0];
              end
            end else if (inrec && (rt == 4'd6 || rt == 4'd7 || rt == 4'd8)) begin
              // packed run
              if (rt == 4'd7 && len[2:0] != 3'd0) begin
                ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                                 pblog_pkg::ERR_PACKDBL, ctw_nxt, rcnt_nxt);
                n_nxt = n_nxt + 2'd1;
                ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
              end else if (len != 64'd0) begin
                irem_nxt = len[15:0];
                ph_nxt = (rt == 4'd7) ? PH_DBL : PH_PACKV;
              end
            end else begin
              if (!inrec && mt == 4'd1) seen_nxt[0] = 1'b1;
              if (inrec && rt == 4'd1) seen_nxt[2] = 1'b1;
              if (len == 64'd0) begin
                ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_EMPTY, 64'd0, 8'd0, 1'b0, 4'd0,
                                                 ctw_nxt, rcnt_nxt);
                n_nxt = n_nxt + 2'd1;
              end else begin
                irem_nxt = len[15:0]; ph_nxt = PH_STR;
              end
            end
          end
        end
        PH_STR: begin
          ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_STR, 64'd0, b, irem_nxt == 16'd0, 4'd0,
                                           ctw_nxt, rcnt_nxt);
          n_nxt = n_nxt + 2'd1;
          if (irem_nxt == 16'd0) ph_nxt = PH_KEY;
        end
        PH_DBL: begin
          acc_nxt = acc_nxt | (64'(b) << {vcnt_nxt[2:0], 3'b000});
          vcnt_nxt = vcnt_nxt + 4'd1;
          if (vcnt_nxt >= 4'd8) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_DBL, acc_nxt, 8'd0, 1'b0, 4'd0,
                                             ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            acc_nxt = 64'd0; vcnt_nxt = 4'd0;
            if (irem_nxt == 16'd0) ph_nxt = PH_KEY;
          end
        end
        PH_PACKV: begin
          acc_nxt = vs_acc; vcnt_nxt = vs_cnt;
          if (vr == 2'd2) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_OVERLONG, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
          end else if (vr == 2'd1) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(ekind, eval, 8'd0, 1'b0, 4'd0, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            acc_nxt = 64'd0; vcnt_nxt = 4'd0;
            if (irem_nxt == 16'd0) ph_nxt = PH_KEY;
          end else if (irem_nxt == 16'd0) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_TRUNC, ctw_nxt, rcnt_nxt);
            n_nxt = n_nxt + 2'd1;
            ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // end of record
      if (ph_nxt != PH_IDLE && inrec && rrem_nxt == 16'd0) begin
        if (ph_nxt != PH_KEY) begin
          ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                           pblog_pkg::ERR_TRUNC, ctw_nxt, rcnt_nxt);
          n_nxt = n_nxt + 2'd1;
          ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
        end else if (!seen_nxt[2]) begin
          ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                           pblog_pkg::ERR_NONAME, ctw_nxt, rcnt_nxt);
          n_nxt = n_nxt + 2'd1;
          ph_nxt = PH_IDLE; seen_nxt[3] = 1'b1;
        end else begin
          ctw_nxt = 11'd10;
          ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_REND, 64'd0, 8'd0, 1'b0, 4'd0,
                                           ctw_nxt, rcnt_nxt);
          n_nxt = n_nxt + 2'd1;
        end
      end

      // end of message
      if (ph_nxt != PH_IDLE && mrem_nxt == 16'd0) begin
        if (ph_nxt != PH_KEY) begin
          ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                           pblog_pkg::ERR_TRUNC, ctw_nxt, rcnt_nxt);
          n_nxt = n_nxt + 2'd1;
        end else begin
          ctw_nxt = 11'd0;
          if (seen_nxt[0] && seen_nxt[1]) begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_OK, 64'd0, 8'd0, 1'b0, 4'd0,
                                             ctw_nxt, rcnt_nxt);
          end else begin
            ev_nxt[n_nxt] = pblog_pkg::mk_ev(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0,
                                             pblog_pkg::ERR_MISSING, ctw_nxt, rcnt_nxt);
            seen_nxt[3] = 1'b1;
          end
          n_nxt = n_nxt + 2'd1;
        end
        if (ph_nxt != PH_KEY) seen_nxt[3] = 1'b1;
        ph_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_KEY;
      acc_r  <= 64'd0;
      vcnt_r <= 4'd0;
      mrem_r <= 16'd0;
      rrem_r <= 16'd0;
      irem_r <= 16'd0;
      ctw_r  <= 11'd0;
      seen_r <= 4'd0;
      rcnt_r <= 16'd0;
    end else if (take) begin
      ph_r   <= ph_nxt;
      acc_r  <= acc_nxt;
      vcnt_r <= vcnt_nxt;
      mrem_r <= mrem_nxt;
      rrem_r <= rrem_nxt;
      irem_r <= irem_nxt;
      ctw_r  <= ctw_nxt;
      seen_r <= seen_nxt;
      rcnt_r <= rcnt_nxt;
    end
  end

endmodule

@@ hdl/pblog_queue.sv @@
// ----------------------------------------------------------------------------
// pblog_queue: two-entry bundle queue
// Decouples the byte parser from the event serialiser.
// ----------------------------------------------------------------------------
module pblog_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pblog_pkg::bundle_t  push_data,
  input  logic                pop,
  output pblog_pkg::bundle_t  head,
  output pblog_pkg::q_stat_t  stat
);

  pblog_pkg::bundle_t ent_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign head       = ent_r[rp_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/pblog_back.sv @@
// ----------------------------------------------------------------------------
// pblog_back: event serialiser
// Sends the events of the head bundle one word at a time.
// ----------------------------------------------------------------------------
module pblog_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pblog_pkg::bundle_t  head,
  input  pblog_pkg::q_stat_t  stat,
  output logic                pop,
  pblog_event_if.source       out_event
);

  logic [1:0]        idx_r;
  logic              last;
  pblog_pkg::event_t e;

  assign e    = head.ev[idx_r];
  assign last = idx_r == (head.cnt - 2'd1);
  assign pop  = out_event.valid && out_event.ready && last;

  assign out_event.valid         = !stat.empty;
  assign out_event.event_kind    = e.event_kind;
  assign out_event.message_tag   = e.message_tag;
  assign out_event.record_tag    = e.record_tag;
  assign out_event.value_word    = e.value_word;
  assign out_event.string_byte   = e.string_byte;
  assign out_event.string_last   = e.string_last;
  assign out_event.record_number = e.record_number;
  assign out_event.error_code    = e.error_code;
  assign out_event.last_of_run   = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_event.valid && out_event.ready) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule

@@ tb/protobuf_log_message_parser_tb.sv @@
// ----------------------------------------------------------------------------
// protobuf_log_message_parser_tb: self-checking bench for the log message parser
// Feeds encoded log messages a word at a time, predicts every event in a
// bench-side decoder and compares each event as it leaves the block. Covers
// the length register, every error path and random messages under stalls.
// ----------------------------------------------------------------------------
module protobuf_log_message_parser_tb;

  typedef enum int {PS_KEY, PS_VARINT, PS_LEN, PS_STR, PS_DBL, PS_PACKV, PS_IDLE} pstate_e;
  typedef logic [7:0] bytes_t[$];
  typedef struct {
    pblog_pkg::event_t ev;
    bit                last;
  } exp_event_t;

  // wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIX64  = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam int UUID_BYTES = 16;
  localparam int SETTLE = 8;  // cycles after the last event before touching cfg

  // varint step outcome
  localparam int VR_PENDING  = 0;
  localparam int VR_DONE     = 1;
  localparam int VR_OVERLONG = 2;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  pblog_byte_if  in_if ();
  pblog_event_if out_if ();

  protobuf_log_message_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_if),
    .out_event (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // decoder state kept by the bench
  pstate_e     dec_state;
  logic [63:0] dec_acc;
  int          dec_vcnt;
  int unsigned msg_left, rec_left, run_left;
  logic [10:0] cur_tags;   // 3:0 message tag, 7:4 record tag, 10:8 wire type
  bit          seen_uuid, seen_ts, seen_name;
  logic [15:0] rec_count;
  logic [7:0]  min_len;

  pblog_pkg::event_t word_events[$];  // events raised by the current word
  exp_event_t        pending_events[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatches;

  // ---------------------------------------------------------------------------
  // Event predictor
  // ---------------------------------------------------------------------------
  function automatic void raise(logic [2:0] kind, logic [63:0] value, logic [7:0] sb,
                                logic sl, logic [3:0] err);
    pblog_pkg::event_t e;
    if (word_events.size() >= pblog_pkg::MaxEv) return;
    e.event_kind    = kind;
    e.message_tag   = cur_tags[3:0];
    e.record_tag    = cur_tags[7:4];
    e.value_word    = value;
    e.string_byte   = sb;
    e.string_last   = sl;
    e.record_number = (cur_tags[3:0] == 4'd10) ? rec_count : 16'd0;
    e.error_code    = err;
    word_events.push_back(e);
  endfunction

  function automatic void abort_msg(logic [3:0] code);
    raise(pblog_pkg::EV_ERR, 64'd0, 8'd0, 1'b0, code);
    dec_state = PS_IDLE;
  endfunction

  function automatic int varint_word(logic [7:0] b);
    if (dec_vcnt < 10) dec_acc |= 64'(b[6:0]) << (7 * dec_vcnt);
    dec_vcnt++;
    if (!b[7]) return VR_DONE;
    if (dec_vcnt >= 10) return VR_OVERLONG;
    return VR_PENDING;
  endfunction

  function automatic void decode_key(logic [7:0] b, bit inrec);
    logic [4:0] tag;
    logic [2:0] wt;
    bit ok;
    tag = b[7:3];
    wt  = b[2:0];
    dec_acc  = 0;
    dec_vcnt = 0;
    if (!inrec) begin
      cur_tags = {wt, 4'd0, tag[3:0]};
      if (tag < 1 || tag > 10) begin
        abort_msg(pblog_pkg::ERR_TAG);
        return;
      end
      ok = (tag == 2 || tag == 5 || tag == 8) ? (wt == WT_VARINT) : (wt == WT_LEN);
    end else begin
      cur_tags = {wt, tag[3:0], 4'd10};
      if (tag < 1 || tag > 8) begin
        abort_msg(pblog_pkg::ERR_TAG);
        return;
      end
      if (tag == 2) ok = (wt == WT_VARINT);
      else if (tag == 6 || tag == 8) ok = (wt == WT_VARINT || wt == WT_LEN);
      else if (tag == 7) ok = (wt == WT_FIX64 || wt == WT_LEN);
      else ok = (wt == WT_LEN);
    end
    if (!ok) abort_msg(pblog_pkg::ERR_WIRE);
    else if (wt == WT_VARINT) dec_state = PS_VARINT;
    else if (wt == WT_LEN) dec_state = PS_LEN;
    else if (rec_left < 8) abort_msg(pblog_pkg::ERR_OVERRUN);
    else begin
      run_left  = 8;
      dec_state = PS_DBL;
    end
  endfunction

  function automatic void length_known(bit inrec);
    logic [63:0] len;
    int unsigned avail;
    logic [3:0] mt, rt;
    len   = dec_acc;
    avail = inrec ? rec_left : msg_left;
    mt    = cur_tags[3:0];
    rt    = cur_tags[7:4];
    dec_acc   = 0;
    dec_vcnt  = 0;
    dec_state = PS_KEY;
    if (len > 64'(avail)) begin
      abort_msg(pblog_pkg::ERR_OVERRUN);
      return;
    end
    if (!inrec) begin
      if (mt == 4'd1) begin
        if (len != UUID_BYTES) begin
          abort_msg(pblog_pkg::ERR_UUID);
          return;
        end
        seen_uuid = 1;
      end
      if (mt == 4'd10) begin
        if (rec_count != 16'hffff) rec_count++;
        seen_name = 0;
        if (len == 0) abort_msg(pblog_pkg::ERR_NONAME);
        else rec_left = len[31:0];
        return;
      end
    end else begin
      if (rt == 4'd1) seen_name = 1;
      if (rt == 4'd6 || rt == 4'd7 || rt == 4'd8) begin
        if (rt == 4'd7 && len[2:0] != 0) begin
          abort_msg(pblog_pkg::ERR_PACKDBL);
          return;
        end
        if (len == 0) return;  // empty packed run: silent
        run_left  = len[31:0];
        dec_state = (rt == 4'd7) ? PS_DBL : PS_PACKV;
        return;
      end
    end
    if (len == 0) begin
      raise(pblog_pkg::EV_EMPTY, 64'd0, 8'd0, 1'b0, 4'd0);
      return;
    end
    run_left  = len[31:0];
    dec_state = PS_STR;
  endfunction

  function automatic void value_out(bit inrec);
    if (inrec && cur_tags[7:4] == 4'd8)
      raise(pblog_pkg::EV_BOOL, (dec_acc != 0) ? 64'd1 : 64'd0, 8'd0, 1'b0, 4'd0);
    else
      raise(pblog_pkg::EV_INT, dec_acc, 8'd0, 1'b0, 4'd0);
  endfunction

  function automatic void predict_word(logic [7:0] b, bit first, logic [15:0] mlen);
    bit inrec;
    int r;
    exp_event_t x;
    word_events.delete();
    if (first) begin
      dec_state = PS_KEY;
      dec_acc   = 0;
      dec_vcnt  = 0;
      msg_left  = 32'(mlen);
      rec_left  = 0;
      run_left  = 0;
      cur_tags  = 0;
      seen_uuid = 0;
      seen_ts   = 0;
      seen_name = 0;
      rec_count = 0;
      if (mlen < min_len) abort_msg(pblog_pkg::ERR_SHORT);
      else if (msg_left == 0) abort_msg(pblog_pkg::ERR_MISSING);
    end
    if (dec_state != PS_IDLE && msg_left != 0) begin
      inrec = (rec_left != 0);
      msg_left--;
      if (inrec) rec_left--;
      if ((dec_state == PS_STR || dec_state == PS_DBL || dec_state == PS_PACKV)
          && run_left > 0)
        run_left--;
      case (dec_state)
        PS_KEY: decode_key(b, inrec);
        PS_VARINT: begin
          r = varint_word(b);
          if (r == VR_OVERLONG) abort_msg(pblog_pkg::ERR_OVERLONG);
          else if (r == VR_DONE) begin
            value_out(inrec);
            if (!inrec && cur_tags[3:0] == 4'd2) seen_ts = 1;
            dec_state = PS_KEY;
          end
        end
        PS_LEN: begin
          r = varint_word(b);
          if (r == VR_OVERLONG) abort_msg(pblog_pkg::ERR_OVERLONG);
          else if (r == VR_DONE) length_known(inrec);
        end
        PS_STR: begin
          raise(pblog_pkg::EV_STR, 64'd0, b, run_left == 0, 4'd0);
          if (run_left == 0) dec_state = PS_KEY;
        end
        PS_DBL: begin
          dec_acc |= 64'(b) << (8 * (dec_vcnt & 7));
          dec_vcnt++;
          if (dec_vcnt >= 8) begin
            raise(pblog_pkg::EV_DBL, dec_acc, 8'd0, 1'b0, 4'd0);
            dec_acc  = 0;
            dec_vcnt = 0;
            if (run_left == 0) dec_state = PS_KEY;
          end
        end
        default: begin  // packed varints
          r = varint_word(b);
          if (r == VR_OVERLONG) abort_msg(pblog_pkg::ERR_OVERLONG);
          else if (r == VR_DONE) begin
            value_out(inrec);
            dec_acc  = 0;
            dec_vcnt = 0;
            if (run_left == 0) dec_state = PS_KEY;
          end else if (run_left == 0) abort_msg(pblog_pkg::ERR_TRUNC);
        end
      endcase
      // record boundary
      if (dec_state != PS_IDLE && inrec && rec_left == 0) begin
        if (dec_state != PS_KEY) abort_msg(pblog_pkg::ERR_TRUNC);
        else if (!seen_name) abort_msg(pblog_pkg::ERR_NONAME);
        else begin
          cur_tags = 11'd10;
          raise(pblog_pkg::EV_REND, 64'd0, 8'd0, 1'b0, 4'd0);
        end
      end
      // message boundary
      if (dec_state != PS_IDLE && msg_left == 0) begin
        if (dec_state != PS_KEY) abort_msg(pblog_pkg::ERR_TRUNC);
        else begin
          cur_tags = 0;
          if (seen_uuid && seen_ts) raise(pblog_pkg::EV_OK, 64'd0, 8'd0, 1'b0, 4'd0);
          else abort_msg(pblog_pkg::ERR_MISSING);
        end
        dec_state = PS_IDLE;
      end
    end
    foreach (word_events[i]) begin
      x.ev   = word_events[i];
      x.last = (i == word_events.size() - 1);
      pending_events.push_back(x);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) out_if.ready = ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    pblog_pkg::event_t got;
    exp_event_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.event_kind    = out_if.event_kind;
      got.message_tag   = out_if.message_tag;
      got.record_tag    = out_if.record_tag;
      got.value_word    = out_if.value_word;
      got.string_byte   = out_if.string_byte;
      got.string_last   = out_if.string_last;
      got.record_number = out_if.record_number;
      got.error_code    = out_if.error_code;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event kind=%0d mtag=%0d err=%0d", got.event_kind,
                   got.message_tag, got.error_code);
      end else begin
        want = pending_events.pop_front();
        if (got !== want.ev || out_if.last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display({"event mismatch: expected kind=%0d mtag=%0d rtag=%0d val=%h",
                      " sb=%h sl=%b rec=%0d err=%0d last=%b"},
                     want.ev.event_kind, want.ev.message_tag, want.ev.record_tag,
                     want.ev.value_word, want.ev.string_byte, want.ev.string_last,
                     want.ev.record_number, want.ev.error_code, want.last);
            $display({"                got      kind=%0d mtag=%0d rtag=%0d val=%h",
                      " sb=%h sl=%b rec=%0d err=%0d last=%b"},
                     got.event_kind, got.message_tag, got.record_tag, got.value_word,
                     got.string_byte, got.string_last, got.record_number, got.error_code,
                     out_if.last_of_run);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Word driver and message builders
  // ---------------------------------------------------------------------------
  // one word across the byte channel; inputs move on the falling edge
  task automatic push_word(logic [7:0] b, bit first, logic [15:0] mlen);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_if.valid = 0;
      @(posedge clk);
    end
    @(negedge clk);
    in_if.valid         = 1;
    in_if.data_byte     = b;
    in_if.first_byte    = first;
    in_if.message_bytes = mlen;
    do @(posedge clk); while (!in_if.ready);
    predict_word(b, first, mlen);
  endtask

  // message_bytes is only looked at on the first word, so junk elsewhere
  task automatic push_msg(bytes_t m, logic [15:0] declared);
    foreach (m[i]) push_word(m[i], i == 0, (i == 0) ? declared : 16'($urandom));
  endtask

  // hold off until the block has emptied, then let it settle
  task automatic drain();
    @(negedge clk);
    in_if.valid = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_min_len(logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_we    = 1;
    cfg_wdata = v;
    @(posedge clk);
    min_len = v;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic void add_varint(ref bytes_t q, input logic [63:0] v);
    do begin
      q.push_back({(v >> 7) != 0, v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endfunction

  function automatic void add_key(ref bytes_t q, input int tag, input logic [2:0] wt);
    q.push_back({tag[4:0], wt});
  endfunction

  function automatic void add_bytes(ref bytes_t q, input int tag, input int n);
    add_key(q, tag, WT_LEN);
    add_varint(q, 64'(n));
    repeat (n) q.push_back(8'($urandom));
  endfunction

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  function automatic void add_uuid_ts(ref bytes_t q);
    add_bytes(q, 1, UUID_BYTES);
    add_key(q, 2, WT_VARINT);
    add_varint(q, rand_value());
  endfunction

  // a field record, named when asked, with a random mix of typed values
  function automatic void add_record(ref bytes_t q, input bit named);
    bytes_t r, p;
    int n;
    if (named) add_bytes(r, 1, $urandom_range(6));
    repeat ($urandom_range(4)) begin
      p.delete();
      case ($urandom_range(9))
        0: begin add_key(r, 2, WT_VARINT); add_varint(r, 64'($urandom_range(5))); end
        1: add_bytes(r, 3, $urandom_range(4));
        2: add_bytes(r, 4, $urandom_range(8));
        3: add_bytes(r, 5, $urandom_range(8));
        4: begin add_key(r, 6, WT_VARINT); add_varint(r, rand_value()); end
        5: begin add_key(r, 8, WT_VARINT); add_varint(r, 64'($urandom_range(2))); end
        6: begin
          add_key(r, 7, WT_FIX64);
          repeat (8) r.push_back(8'($urandom));
        end
        7: begin
          n = 8 * $urandom_range(2);
          add_key(r, 7, WT_LEN);
          add_varint(r, 64'(n));
          repeat (n) r.push_back(8'($urandom));
        end
        default: begin
          repeat ($urandom_range(3)) add_varint(p, rand_value());
          add_key(r, $urandom_range(1) ? 6 : 8, WT_LEN);
          add_varint(r, 64'(p.size()));
          r = {r, p};
        end
      endcase
    end
    add_key(q, 10, WT_LEN);
    add_varint(q, 64'(r.size()));
    q = {q, r};
  endfunction

  function automatic bytes_t good_msg();
    bytes_t q;
    add_uuid_ts(q);
    repeat ($urandom_range(3)) begin
      case ($urandom_range(3))
        0: add_bytes(q, 3 + 3 * $urandom_range(1), $urandom_range(5));
        1: begin
          add_key(q, $urandom_range(1) ? 5 : 8, WT_VARINT);
          add_varint(q, rand_value());
        end
        2: add_bytes(q, $urandom_range(1) ? 7 : 9, $urandom_range(5));
        default: add_record(q, 1);
      endcase
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // length register at both ends and the reset value
  task automatic test_min_length();
    bytes_t q;
    push_word(8'h0a, 0, 16'h0000);  // stray words before any message: silent
    push_word(8'hff, 0, 16'hffff);
    write_min_len(8'd0);
    push_word(8'h55, 1, 16'd0);     // zero length: missing fields
    push_word(8'h55, 0, 16'd3);     // ignored after the error
    q = good_msg();
    push_msg(q, 16'(q.size()));
    write_min_len(8'd255);
    push_msg(q, 16'(q.size()));     // too short
    write_min_len(8'd20);
    push_word(8'h0a, 1, 16'd19);
    q.delete();
    add_uuid_ts(q);
    push_msg(q, 16'(q.size()));
    // huge declared length, cut off by a restart
    push_word(8'h0a, 1, 16'hffff);
    push_word(8'h10, 0, 16'h0000);
  endtask

  // every error path and the awkward corners of the wire format
  task automatic test_errors();
    bytes_t q;
    write_min_len(8'd0);
    q = '{8'h58};  push_msg(q, 16'd4);              // tag 11
    q = '{8'h02};  push_msg(q, 16'd4);              // tag 0
    q = '{8'h0b};  push_msg(q, 16'd4);              // uuid with wire type 3
    q = '{8'h10};  repeat (10) q.push_back(8'hff); push_msg(q, 16'd12);  // overlong
    q = '{8'h0a, 8'h64}; push_msg(q, 16'd5);        // length overrun
    q = '{8'h0a, 8'h0f}; push_msg(q, 16'd20);       // uuid of 15
    q = '{8'h52, 8'h00}; push_msg(q, 16'd4);        // empty record
    q.delete(); add_uuid_ts(q); add_record(q, 0); push_msg(q, 16'(q.size()));
    q.delete(); add_bytes(q, 1, UUID_BYTES); push_msg(q, 16'(q.size()));  // no timestamp
    q.delete(); add_bytes(q, 3, 5); push_msg(q, 16'(q.size() - 2));       // string too long
    q = '{8'h10, 8'h80}; push_msg(q, 16'd2);        // cut mid-varint
    q = '{8'h52, 8'h04, 8'h0a, 8'h00, 8'h3a, 8'h07}; push_msg(q, 16'd6);  // packed dbl 7
    q = '{8'h52, 8'h05, 8'h0a, 8'h00, 8'h39, 8'h01, 8'h02};
    push_msg(q, 16'd7);                             // fix64 short
    q = '{8'h52, 8'h04, 8'h0a, 8'h00, 8'h32, 8'h01, 8'h80};
    push_msg(q, 16'd7);                             // packed cut
    // empty string, empty packed run, packed bools, a double overrunning its record, integer extremes
    q.delete();
    add_uuid_ts(q);
    add_bytes(q, 4, 0);
    add_key(q, 5, WT_VARINT); add_varint(q, 64'hffff_ffff_ffff_ffff);
    add_key(q, 8, WT_VARINT); add_varint(q, 64'd0);
    q = {q, 8'h52, 8'h11, 8'h0a, 8'h01, 8'h41, 8'h32, 8'h00, 8'h42, 8'h02, 8'h00, 8'h05,
         8'h39, 8'hff, 8'h00, 8'h80, 8'h7f, 8'h01, 8'hfe, 8'h10, 8'hef};
    push_msg(q, 16'(q.size()));
  endtask

  // mostly well-formed messages, some damaged, a few pure noise
  task automatic test_random(int words);
    bytes_t q;
    int sent;
    int dlen;
    sent = 0;
    while (sent < words) begin
      q = good_msg();
      dlen = q.size();
      case ($urandom_range(19))
        0, 1, 2: q[$urandom_range(q.size() - 1)] = 8'($urandom);
        3, 4: dlen = q.size() - $urandom_range(1, 4);
        5: dlen = q.size() + $urandom_range(1, 3);
        6: begin
          q.delete();
          repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
          dlen = $urandom_range(1, 20);
        end
        default: ;
      endcase
      if (dlen > q.size()) dlen = q.size();  // never overrun what is sent
      push_msg(q, 16'(dlen));
      sent += q.size();
      if ($urandom_range(9) == 0) drain();  // let everything out before going on
    end
  endtask

  initial begin
    mismatches  = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_n       = 0;
    cfg_we      = 0;
    cfg_wdata   = 0;
    in_if.valid         = 0;
    in_if.data_byte     = 0;
    in_if.first_byte    = 0;
    in_if.message_bytes = 0;
    dec_state = PS_KEY;
    dec_acc   = 0;
    dec_vcnt  = 0;
    msg_left  = 0;
    rec_left  = 0;
    run_left  = 0;
    cur_tags  = 0;
    seen_uuid = 0;
    seen_ts   = 0;
    seen_name = 0;
    rec_count = 0;
    min_len   = pblog_pkg::MIN_LEN_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    tx_idle_pct = 36;
    rx_idle_pct = 88;
    test_min_length();
    test_errors();
    write_min_len(8'd20);
    test_random(20);
    tx_idle_pct = 88;
    rx_idle_pct = 36;
    write_min_len(8'd12);
    test_random(20);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_min_len(8'd20);
    test_random(20);

    drain();
    if (mismatches == 0) begin
      $display("[protobuf_log_message_parser] OK");
    end else begin
      $display("[protobuf_log_message_parser] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("[protobuf_log_message_parser] ERROR");
    $finish;
  end

endmodule
